// File: hdl/msort_pkg.sv
// Shared constants and controller/datapath interface types for the sorter.
package msort_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // controller -> datapath
  typedef struct packed {
    logic insert;    // place the input value into the cell row
    logic pop;       // move cell 0 into the output register, shift row down
    logic pop_last;  // result being popped is the final one of the run
    logic pop_ovf;   // run dropped elements
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic one_left;
    logic full;
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

// File: hdl/msort_ctrl.sv
// Sequencer: load phase, emit phase and run overflow tracking.
module msort_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  input  msort_pkg::dp_stat_t stat,
  output msort_pkg::ctl_cmd_t cmd
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  logic ovf_r, ovf_nxt;
  logic accept;

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid & in_ready;

  always_comb begin
    cmd          = '0;
    cmd.insert   = accept & ~stat.full;
    cmd.pop      = (state_r == ST_EMIT) & stat.out_free & ~stat.empty;
    cmd.pop_last = stat.one_left;
    cmd.pop_ovf  = ovf_r;
  end

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && stat.full) ovf_nxt = 1'b1;
        if (accept && in_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.pop && stat.one_left) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty) else $error("pop from empty store");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !stat.empty) else $error("emit phase with empty store");

  a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && stat.one_left) |=> !ovf_r) else $error("overflow not cleared after run");
`endif

endmodule

// File: hdl/msort_dp.sv
// Insertion cell row, fill count and result output register.
module msort_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic signed [msort_pkg::DATA_W-1:0]     in_value,
  input  msort_pkg::ctl_cmd_t                     cmd,
  output msort_pkg::dp_stat_t                     stat,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic signed [msort_pkg::DATA_W-1:0]     out_sorted_value,
  output logic                                    out_last_out,
  output logic                                    out_overflow
);

  logic signed [msort_pkg::DATA_W-1:0] cell_r   [msort_pkg::DEPTH];
  logic signed [msort_pkg::DATA_W-1:0] cell_nxt [msort_pkg::DEPTH];
  logic [msort_pkg::DEPTH-1:0]         lt;
  logic [msort_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                                out_valid_r;
  logic signed [msort_pkg::DATA_W-1:0] out_value_r;
  logic                                out_last_r;
  logic                                out_ovf_r;

  // Each occupied cell holding a value strictly below the new one keeps it;
  // the first other cell takes the new value, the rest shift up by one.
  for (genvar gi = 0; gi < msort_pkg::DEPTH; gi++) begin : g_cell
    assign lt[gi] = (msort_pkg::CNT_W'(gi) < count_r) && (cell_r[gi] < in_value);

    always_comb begin
      cell_nxt[gi] = cell_r[gi];
      if (cmd.insert) begin
        if (!lt[gi]) begin
          if (gi == 0) begin
            cell_nxt[gi] = in_value;
          end else begin
            cell_nxt[gi] = lt[(gi > 0) ? gi - 1 : 0] ? in_value
                                                     : cell_r[(gi > 0) ? gi - 1 : 0];
          end
        end
      end else if (cmd.pop) begin
        if (gi < msort_pkg::DEPTH - 1) begin
          cell_nxt[gi] = cell_r[(gi < msort_pkg::DEPTH - 1) ? gi + 1 : gi];
        end
      end
    end

    always_ff @(posedge clk) begin
      cell_r[gi] <= cell_nxt[gi];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) count_nxt = count_r + msort_pkg::CNT_W'(1);
    else if (cmd.pop) count_nxt = count_r - msort_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.pop) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_value_r <= cell_r[0];
      out_last_r  <= cmd.pop_last;
      out_ovf_r   <= cmd.pop_ovf;
    end
  end

  always_comb begin
    stat          = '0;
    stat.empty    = (count_r == '0);
    stat.one_left = (count_r == msort_pkg::CNT_W'(1));
    stat.full     = (count_r == msort_pkg::CNT_W'(msort_pkg::DEPTH));
    stat.out_free = ~out_valid_r | out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= msort_pkg::CNT_W'(msort_pkg::DEPTH)) else $error("fill count past depth");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.pop)) else $error("insert and pop together");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> count_r == $past(count_r) + msort_pkg::CNT_W'(1))
    else $error("insert did not advance fill count");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> out_valid_r) else $error("popped result not presented");
`endif

endmodule

// File: hdl/merge_insertion_sorter.sv
// One input transfer per cycle while loading. After the last-marked transfer the state
//   register enters emit, and once the output register is free a pop loads it with the
//   first result; then one result per cycle while out_ready stays high. in_ready is low
//   for the whole emit phase, which stretches while the output register is held.
// Reset (synchronous, rst_n low) empties the store, clears overflow and drops any result;
//   cell contents are not cleared.
module merge_insertion_sorter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [msort_pkg::DATA_W-1:0] in_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [msort_pkg::DATA_W-1:0] out_sorted_value,
  output logic                                out_last_out,
  output logic                                out_overflow
);

  msort_pkg::ctl_cmd_t cmd;
  msort_pkg::dp_stat_t stat;

  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msort_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule
